>>> hw/rtl/nta_pkg.sv
package nta_pkg;

  // Format modes carried on in_tuser
  typedef enum logic [2:0] {
    OP_UDEC    = 3'd0,
    OP_SDEC    = 3'd1,
    OP_OCT     = 3'd2,
    OP_HEX     = 3'd3,
    OP_HEX_PFX = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  localparam int unsigned W_BITS = 6;   // min_width field
  localparam int unsigned IN_VALUE_BITS = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;

  // "0123456789ABCDEF"
  localparam logic [0:15][7:0] DIGIT_CHARS = {
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

>>> hw/rtl/number_to_ascii_formatter.sv
// Integer to ASCII formatter. One input transaction carries a number (in_tdata[31:0]), a
// minimum width and a pad choice, with the format mode on in_tuser; the block returns the
// characters of the number most significant first, one output transaction each, with
// out_tlast on the final one. Modes: unsigned decimal, signed decimal ('-' first, counts
// toward the width), octal, upper-case hex, hex with a "0x" prefix (not counted in the
// width). Padding always follows any sign or prefix; widths above MAX_WIDTH saturate.
// Unused mode codes are consumed and produce nothing. Only one number is in flight at a
// time: in_tready is high only in the idle state between numbers. After a number is loaded,
// decimal modes run a bit-serial binary to BCD shifter (add-3 per BCD digit, one value bit
// per cycle); all modes then drop leading zero slots (up to (VALUE_BITS+2)/3 - 1, keeping
// at least one digit), then emit the characters, one per cycle while out_tready stays high,
// a receiver stall holding the current character until it is taken.
module number_to_ascii_formatter #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [37:32] min_width, [38] pad_with_spaces
  input  logic [2:0]  in_tuser,   // [2:0] op
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast   // last character of the number
);

  import nta_pkg::*;

  // digit store: enough 4-bit slots for the octal form, which is always the longest
  localparam int unsigned NDIG   = (VALUE_BITS + 2) / 3;
  localparam int unsigned O_BITS = NDIG * 3;
  localparam int unsigned H_BITS = NDIG * 4;
  localparam int unsigned DW     = $clog2(NDIG + 1);
  localparam int unsigned CW     = $clog2(VALUE_BITS + 1);
  localparam int unsigned CB     = (VALUE_BITS < IN_VALUE_BITS) ? VALUE_BITS : IN_VALUE_BITS;

  state_t              state_r, state_nxt;
  logic [H_BITS-1:0]   digs_r, digs_nxt;        // digit slots, most significant at top
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;        // BCD shifter source
  logic [CW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [DW-1:0]       dig_left_r, dig_left_nxt; // significant digits still to send
  logic [W_BITS-1:0]   width_r, width_nxt;      // characters still owed by pad + digits
  logic [1:0]          pre_cnt_r, pre_cnt_nxt;  // sign / prefix characters still to send
  logic                neg_r, neg_nxt;
  logic                pad_sp_r, pad_sp_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  // input decode
  op_t                 in_op;
  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] mag;
  logic                in_neg;
  logic [W_BITS-1:0]   in_width;
  logic [W_BITS-1:0]   w_sat;
  logic                in_acc;
  logic                op_ok;
  logic                is_dec;

  logic [H_BITS-1:0]   dabble;
  logic [H_BITS-1:0]   oct_load;
  logic [O_BITS-1:0]   oct_bits;
  logic [3:0]          top_dig;
  logic                out_free;
  logic                skip_more;
  logic                pad_due;

  assign in_op    = op_t'(in_tuser);
  assign v_in     = VALUE_BITS'(in_tdata[CB-1:0]);
  assign in_width = in_tdata[37:32];
  assign in_acc   = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  assign top_dig   = digs_r[H_BITS-1 -: 4];
  assign out_free  = !out_valid_r || out_tready;
  assign skip_more = (dig_left_r > DW'(1)) && (top_dig == 4'd0);
  assign pad_due   = width_r > W_BITS'(dig_left_r);

  always_comb begin
    unique case (in_op)
      OP_UDEC, OP_SDEC, OP_OCT, OP_HEX, OP_HEX_PFX: op_ok = 1'b1;
      default:                                      op_ok = 1'b0;
    endcase
  end

  assign is_dec = (in_op == OP_UDEC) || (in_op == OP_SDEC);
  assign in_neg = (in_op == OP_SDEC) && v_in[VALUE_BITS-1];
  assign mag    = in_neg ? (~v_in) + VALUE_BITS'(1) : v_in;
  assign w_sat  = (in_width > W_BITS'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH) : in_width;

  // octal: 3-bit groups zero-extended into the 4-bit slots
  assign oct_bits = O_BITS'(mag);
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_load[4*i +: 4] = {1'b0, oct_bits[3*i +: 3]};
    end
  end

  // one double-dabble step: add 3 to each BCD digit of 5 or more, then shift in a bit
  always_comb begin
    logic [H_BITS-1:0] adj;
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (digs_r[4*i +: 4] >= 4'd5) ? digs_r[4*i +: 4] + 4'd3
                                                 : digs_r[4*i +: 4];
    end
    dabble = {adj[H_BITS-2:0], bin_r[VALUE_BITS-1]};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op_ok) begin
          state_nxt = is_dec ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == CW'(1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!skip_more) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (pre_cnt_r == 2'd0) && !pad_due && (dig_left_r == DW'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    digs_nxt      = digs_r;
    bin_nxt       = bin_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_left_nxt  = dig_left_r;
    width_nxt     = width_r;
    pre_cnt_nxt   = pre_cnt_r;
    neg_nxt       = neg_r;
    pad_sp_nxt    = pad_sp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          bin_nxt      = mag;
          bit_cnt_nxt  = CW'(VALUE_BITS);
          dig_left_nxt = DW'(NDIG);
          neg_nxt      = in_neg;
          pad_sp_nxt   = in_tdata[38];
          // the minus sign uses up one place of the width
          width_nxt    = (in_neg && (w_sat != '0)) ? w_sat - W_BITS'(1) : w_sat;
          pre_cnt_nxt  = in_neg ? 2'd1 : ((in_op == OP_HEX_PFX) ? 2'd2 : 2'd0);
          unique case (in_op)
            OP_OCT:             digs_nxt = oct_load;
            OP_HEX, OP_HEX_PFX: digs_nxt = H_BITS'(mag);
            default:            digs_nxt = '0;
          endcase
        end
      end
      ST_CONV: begin
        digs_nxt    = dabble;
        bin_nxt     = {bin_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - CW'(1);
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (skip_more) begin
          digs_nxt     = {digs_r[H_BITS-5:0], 4'd0};
          dig_left_nxt = dig_left_r - DW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          priority if (pre_cnt_r != 2'd0) begin
            pre_cnt_nxt  = pre_cnt_r - 2'd1;
            out_char_nxt = neg_r ? CH_MINUS : ((pre_cnt_r == 2'd2) ? CH_ZERO : CH_X);
          end else if (pad_due) begin
            width_nxt    = width_r - W_BITS'(1);
            out_char_nxt = pad_sp_r ? CH_SPACE : CH_ZERO;
          end else begin
            out_char_nxt = digit_char(top_dig);
            out_last_nxt = (dig_left_r == DW'(1));
            digs_nxt     = {digs_r[H_BITS-5:0], 4'd0};
            dig_left_nxt = dig_left_r - DW'(1);
            if (width_r != '0) begin
              width_nxt = width_r - W_BITS'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digs_r     <= digs_nxt;
    bin_r      <= bin_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    width_r    <= width_nxt;
    pre_cnt_r  <= pre_cnt_nxt;
    neg_r      <= neg_nxt;
    pad_sp_r   <= pad_sp_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nta_pkg::*;

  // Run limits. A number has at most 34 characters, each of which may wait out receiver
  // stalls. The limit is many times the slowest expected run.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 120;   // block latency plus margin
  localparam int unsigned LONG_HOLD     = 500;   // receiver hold-off, in cycles
  localparam int unsigned PHASE_ITEMS   = 82;    // real-mode numbers per random phase
  localparam int unsigned WIDTH_CAP     = 32;    // MAX_WIDTH of the block
  localparam int unsigned MAX_REPORTS   = 20;

  // Mode codes the block consumes without output
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Traffic phases: no idling, sender idle, receiver stalling, both
  localparam int SEND_IDLE  [4] = '{0, 86, 0, 17};
  localparam int RECV_STALL [4] = '{0, 0, 86, 17};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_txn_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  min_w;
    logic        pad_sp;
    bit          typed;   // expected text given in the row
    string       text;
  } fmt_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] value, [37:32] min_width, [38] pad_with_spaces
  logic [2:0]  in_tuser   = '0;   // [2:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] character
  logic        out_tlast;

  char_txn_t   pending_chars [$];  // characters still owed by the block, oldest first
  logic [7:0]  line_buf [$];       // scratch: characters of one formatted number

  int unsigned cycle          = 0;
  int unsigned mismatches     = 0;
  int unsigned chars_checked  = 0;
  int unsigned numbers_sent   = 0;
  int unsigned unused_sent    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        long_hold_go   = 1'b0;
  int unsigned hold_count     = 0;

  number_to_ascii_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d characters outstanding", cycle,
               pending_chars.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH cycle %0d: %s", cycle, what);
  endtask

  // Formats one number into line_buf. Unused modes leave it empty.
  function automatic void format_number(input logic [2:0] op, input logic [31:0] value,
                                        input logic [5:0] min_w, input logic pad_sp);
    logic [7:0]  digits [$];
    logic [31:0] mag;
    logic [31:0] base;
    logic [3:0]  d;
    int unsigned width;
    logic [7:0]  pad_ch;
    line_buf.delete();
    if (op > OP_HEX_PFX) return;
    width  = (min_w > WIDTH_CAP) ? WIDTH_CAP : min_w;
    pad_ch = pad_sp ? CH_SPACE : CH_ZERO;
    mag    = value;
    case (op)
      OP_UDEC, OP_SDEC: base = 32'd10;
      OP_OCT:           base = 32'd8;
      default:          base = 32'd16;
    endcase
    // minus goes first and takes one place of the width; most negative wraps to itself
    if (op == OP_SDEC && value[31]) begin
      line_buf.push_back(CH_MINUS);
      mag = -value;
      if (width > 0) width--;
    end
    // prefix sits outside the width
    if (op == OP_HEX_PFX) begin
      line_buf.push_back(CH_ZERO);
      line_buf.push_back(CH_X);
    end
    do begin
      d = 4'(mag % base);
      digits.push_front(d < 4'd10 ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d) - 8'd10);
      mag = mag / base;
    end while (mag != 0);
    for (int i = digits.size(); i < width; i++)
      line_buf.push_back(pad_ch);
    foreach (digits[k])
      line_buf.push_back(digits[k]);
  endfunction

  // Offers one number, waits for its transaction, then queues the characters it owes.
  // Only one nonblocking write to in_tvalid per time step.
  task automatic send_number(input logic [2:0] op, input logic [31:0] value,
                             input logic [5:0] min_w, input logic pad_sp,
                             input bit typed, input string text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pad_sp, min_w, value};
    in_tuser  <= op;
    do begin
      @(posedge clk);
    end while (!in_tready);
    if (typed) begin
      line_buf.delete();
      for (int k = 0; k < text.len(); k++)
        line_buf.push_back(8'(text[k]));
    end else begin
      format_number(op, value, min_w, pad_sp);
    end
    foreach (line_buf[k])
      pending_chars.push_back('{ch: line_buf[k], last: (k == line_buf.size() - 1)});
    numbers_sent++;
    if (op > OP_HEX_PFX) unused_sent++;
  endtask

  // Sender stops and waits for every owed character
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0)
      @(posedge clk);
  endtask

  // Receiver: random stalls per phase, plus one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_go && hold_count < LONG_HOLD) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Each output transaction against the oldest owed character
  always @(posedge clk) begin : char_check
    char_txn_t want;
    if (rst_n && out_tvalid && out_tready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_tdata, out_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last)
          report_mismatch($sformatf("got char 0x%02h last=%0b, expected char 0x%02h last=%0b",
                                    out_tdata, out_tlast, want.ch, want.last));
      end
    end
  end

  initial begin : stimulus
    fmt_row_t    rows [$];
    logic [2:0]  r_op;
    logic [31:0] r_val;
    logic [5:0]  r_w;
    int unsigned valid_count;

    // Directed table: extremes, each mode, sign and padding cases, unused modes
    rows.push_back('{OP_UDEC,    32'h0000_0000, 6'd0,  1'b0, 1'b1, "0"});
    rows.push_back('{OP_UDEC,    32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "4294967295"});
    rows.push_back('{OP_SDEC,    32'h8000_0000, 6'd0,  1'b0, 1'b1, "-2147483648"});
    rows.push_back('{OP_SDEC,    32'h7FFF_FFFF, 6'd0,  1'b1, 1'b1, "2147483647"});
    rows.push_back('{OP_SDEC,    32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "-1"});
    rows.push_back('{OP_SDEC,    32'h0000_0000, 6'd1,  1'b1, 1'b1, "0"});
    rows.push_back('{OP_SDEC,    32'hFFFF_FFFF, 6'd1,  1'b0, 1'b1, "-1"});
    rows.push_back('{OP_OCT,     32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "37777777777"});
    rows.push_back('{OP_OCT,     32'h0000_0008, 6'd0,  1'b1, 1'b1, "10"});
    rows.push_back('{OP_HEX,     32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "FFFFFFFF"});
    rows.push_back('{OP_HEX_PFX, 32'h0000_0000, 6'd0,  1'b0, 1'b1, "0x0"});
    rows.push_back('{OP_HEX_PFX, 32'hDEAD_BEEF, 6'd0,  1'b1, 1'b1, "0xDEADBEEF"});
    rows.push_back('{OP_UDEC,    32'd42,        6'd5,  1'b0, 1'b1, "00042"});
    rows.push_back('{OP_UDEC,    32'd42,        6'd5,  1'b1, 1'b1, "   42"});
    rows.push_back('{OP_SDEC,    32'hFFFF_FFD6, 6'd5,  1'b0, 1'b1, "-0042"});
    rows.push_back('{OP_SDEC,    32'hFFFF_FFD6, 6'd5,  1'b1, 1'b1, "-  42"});
    rows.push_back('{OP_HEX_PFX, 32'h0000_00AB, 6'd4,  1'b0, 1'b1, "0x00AB"});
    rows.push_back('{OP_RSVD5,   32'd1234,      6'd8,  1'b0, 1'b1, ""});
    rows.push_back('{OP_RSVD6,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, ""});
    rows.push_back('{OP_RSVD7,   32'h0000_0000, 6'd0,  1'b0, 1'b1, ""});
    // wide widths up to and beyond the cap, including the longest possible output
    rows.push_back('{OP_UDEC,    32'd7,         6'd32, 1'b1, 1'b0, ""});
    rows.push_back('{OP_UDEC,    32'd12345678,  6'd63, 1'b0, 1'b0, ""});
    rows.push_back('{OP_SDEC,    32'h8000_0000, 6'd33, 1'b1, 1'b0, ""});
    rows.push_back('{OP_HEX_PFX, 32'h0000_0001, 6'd40, 1'b0, 1'b0, ""});
    rows.push_back('{OP_OCT,     32'h1234_5670, 6'd20, 1'b1, 1'b0, ""});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_number(rows[i].op, rows[i].value, rows[i].min_w, rows[i].pad_sp,
                  rows[i].typed, rows[i].text);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct   = SEND_IDLE[phase];
      recv_stall_pct <= RECV_STALL[phase];
      valid_count     = 0;
      while (valid_count < PHASE_ITEMS) begin
        // mostly real modes, a few unused codes as noise
        r_op = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 4))
              0:       r_val = 32'h0000_0000;
              1:       r_val = 32'hFFFF_FFFF;
              2:       r_val = 32'h8000_0000;
              3:       r_val = 32'h7FFF_FFFF;
              default: r_val = 32'h8000_0001;
            endcase
          end
          1, 2, 3: r_val = $urandom_range(0, 255);
          4:       r_val = -$urandom_range(1, 1000);
          5:       r_val = 32'h1 << $urandom_range(0, 31);
          default: r_val = $urandom;
        endcase
        // narrow widths dominate; now and then up to and past the cap
        case ($urandom_range(0, 9))
          0:       r_w = 6'($urandom_range(0, 63));
          1, 2:    r_w = 6'($urandom_range(0, 34));
          default: r_w = 6'($urandom_range(0, 12));
        endcase
        send_number(r_op, r_val, r_w, 1'($urandom_range(0, 1)), 1'b0, "");
        if (r_op <= OP_HEX_PFX) valid_count++;
        // long receiver hold-off while the sender keeps offering
        if (phase == 0 && valid_count == 10) long_hold_go <= 1'b1;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d numbers sent (%0d in unused modes), %0d characters checked",
             numbers_sent, unused_sent, chars_checked);
    $display("Summary: directed table, then four traffic phases incl. a %0d-cycle hold-off",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/nta_pkg.sv
hw/rtl/number_to_ascii_formatter.sv
tb/testbench.sv
